FILE: hw/rtl/ssoc_pkg.sv
// ----------------------------------------------------------------------------
// ssoc_pkg
// Shared types and constants of the sorted sequence occurrence counter.
// ----------------------------------------------------------------------------
`default_nettype none

package ssoc_pkg;

  localparam int ITEM_W   = 16;
  localparam int OCC_W    = 11;
  localparam int STATUS_W = 2;
  localparam int CMD_W    = 2;

  // Command codes of the input channel.
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Status codes reported with each result.
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LONG = 2'd2;

  // Outcome of one step of the sequence comparator.
  typedef struct packed {
    logic done;
    logic gt;
    logic lt;
  } cmp_res_t;

  // Completion of a query search.
  typedef struct packed {
    logic             done;
    logic [OCC_W-1:0] occ;
  } srch_res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sorted_sequence_occurrence_counter_top.sv
// ----------------------------------------------------------------------------
// sorted_sequence_occurrence_counter_top
// Table of item sequences with equal-range counting of a streamed query.
// ----------------------------------------------------------------------------
// Every input transfer that is a load item, a clear or an unused command is
// absorbed when it is accepted; a load or query transfer marked last yields one
// result transfer. A query that ends without an error starts two binary
// searches over the stored entries (upper bound, then lower bound). Each
// probe forms the midpoint, issues the first memory reads and then walks the
// single read port of the entry item memory one item per cycle, comparing up
// to the length of the shorter of the two sequences plus one. The input is
// not ready during the search. Entries must be loaded in ascending
// lexicographic order, a shorter prefix first; the order is not checked.
// No memory needs clearing after reset, since only stored entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_sequence_occurrence_counter_top #(
  parameter int TABLE_DEPTH = 1024,
  parameter int MAX_SEQ_LEN = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ssoc_pkg::CMD_W-1:0]      cmd,
  input  logic [ssoc_pkg::ITEM_W-1:0]     item_id,
  input  logic                            no_item,
  input  logic                            last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ssoc_pkg::OCC_W-1:0]      occurrences,
  output logic [ssoc_pkg::STATUS_W-1:0]   status
);

  // Row index, entry count, column index and sequence length widths.
  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int LW    = (MAX_SEQ_LEN > 1) ? $clog2(MAX_SEQ_LEN) : 1;
  localparam int LEN_W = $clog2(MAX_SEQ_LEN + 1);

  // Sequence state. The open sequence's kind is 0 for a load, 1 for a query.
  logic [CW-1:0]                  entry_count;
  logic [LEN_W-1:0]               current_length;
  logic [ssoc_pkg::STATUS_W-1:0]  error_pending;
  logic                           seq_kind;
  logic                           busy;
  logic [LEN_W-1:0]               qlen;

  // Decode of the transfer being accepted.
  logic                           acc;
  logic                           is_ld;
  logic                           is_qry;
  logic                           is_seq;
  logic                           kind_chg;
  logic [LEN_W-1:0]               cl0;
  logic [LEN_W-1:0]               cl1;
  logic [ssoc_pkg::STATUS_W-1:0]  err0;
  logic [ssoc_pkg::STATUS_W-1:0]  err1;
  logic [ssoc_pkg::STATUS_W-1:0]  err2;
  logic                           tbl_full;
  logic                           seq_full;
  logic                           store;
  logic                           finish;
  logic                           commit;
  logic                           launch;
  logic                           post_result;

  // Memory and search connections.
  logic [AW-1:0]                  srch_row;
  logic [LW-1:0]                  srch_col;
  logic [LEN_W-1:0]               ent_len;
  logic [ssoc_pkg::ITEM_W-1:0]    ent_item;
  logic [ssoc_pkg::ITEM_W-1:0]    qry_item;
  ssoc_pkg::srch_res_t            srch_res;

  // A new transfer is taken only when the result register is free or being
  // emptied in the same cycle, so any result it causes always has a slot.
  assign in_ready = !busy && (!out_valid || out_ready);
  assign acc      = in_valid && in_ready;

  assign is_ld    = (cmd == ssoc_pkg::CMD_LOAD);
  assign is_qry   = (cmd == ssoc_pkg::CMD_QUERY);
  assign is_seq   = is_ld || is_qry;

  // Switching between load and query drops the open partial sequence.
  assign kind_chg = (seq_kind != is_qry);
  assign cl0      = kind_chg ? '0 : current_length;
  assign err0     = kind_chg ? ssoc_pkg::ST_OK : error_pending;

  // A full table wins over every other error.
  assign tbl_full = (entry_count == CW'(TABLE_DEPTH));
  assign err1     = (is_ld && tbl_full) ? ssoc_pkg::ST_FULL : err0;

  assign seq_full = (cl0 >= LEN_W'(MAX_SEQ_LEN));

  always_comb begin
    err2 = err1;
    if (!no_item && seq_full && err1 == ssoc_pkg::ST_OK) begin
      err2 = ssoc_pkg::ST_LONG;
    end
  end

  assign store  = acc && is_seq && !no_item && !seq_full && (err1 == ssoc_pkg::ST_OK);
  assign cl1    = store ? (cl0 + LEN_W'(1)) : cl0;
  assign finish = acc && is_seq && last;
  assign commit = finish && is_ld && (err2 == ssoc_pkg::ST_OK);
  assign launch = finish && is_qry && (err2 == ssoc_pkg::ST_OK);

  // A result is posted at once for a load end or a flagged query, and when a
  // search completes.
  assign post_result = (finish && !launch) || srch_res.done;

  // Entry items, one row of 2**LW columns per entry.
  ssoc_ram #(
    .WIDTH(ssoc_pkg::ITEM_W),
    .DEPTH(TABLE_DEPTH * (2 ** LW))
  ) u_ent_item_ram (
    .clk    (clk),
    .wr_en  (store && is_ld),
    .wr_addr({entry_count[AW-1:0], cl0[LW-1:0]}),
    .wr_data(item_id),
    .rd_addr({srch_row, srch_col}),
    .rd_data(ent_item)
  );

  // Entry lengths, written when a load sequence closes cleanly.
  ssoc_ram #(
    .WIDTH(LEN_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ent_len_ram (
    .clk    (clk),
    .wr_en  (commit),
    .wr_addr(entry_count[AW-1:0]),
    .wr_data(cl1),
    .rd_addr(srch_row),
    .rd_data(ent_len)
  );

  // Items of the query being streamed.
  ssoc_ram #(
    .WIDTH(ssoc_pkg::ITEM_W),
    .DEPTH(2 ** LW)
  ) u_qry_ram (
    .clk    (clk),
    .wr_en  (store && is_qry),
    .wr_addr(cl0[LW-1:0]),
    .wr_data(item_id),
    .rd_addr(srch_col),
    .rd_data(qry_item)
  );

  ssoc_search #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .MAX_SEQ_LEN(MAX_SEQ_LEN)
  ) u_search (
    .clk     (clk),
    .rst     (rst),
    .start   (launch),
    .count   (entry_count),
    .qlen    (qlen),
    .ent_len (ent_len),
    .ent_item(ent_item),
    .qry_item(qry_item),
    .rd_row  (srch_row),
    .rd_col  (srch_col),
    .res     (srch_res)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count    <= '0;
      current_length <= '0;
      error_pending  <= ssoc_pkg::ST_OK;
      seq_kind       <= 1'b0;
      busy           <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      out_valid <= post_result || (out_valid && !out_ready);
      if (acc) begin
        case (cmd)
          ssoc_pkg::CMD_CLEAR: begin
            entry_count    <= '0;
            current_length <= '0;
            error_pending  <= ssoc_pkg::ST_OK;
          end
          ssoc_pkg::CMD_LOAD, ssoc_pkg::CMD_QUERY: begin
            seq_kind <= is_qry;
            if (last) begin
              current_length <= '0;
              error_pending  <= ssoc_pkg::ST_OK;
              if (commit) begin
                entry_count <= entry_count + CW'(1);
              end
              if (launch) begin
                busy <= 1'b1;
              end
            end else begin
              current_length <= cl1;
              error_pending  <= err2;
            end
          end
          default: ;
        endcase
      end
      if (srch_res.done) begin
        busy <= 1'b0;
      end
    end
  end

  // Result payload and the query length held for the search.
  always_ff @(posedge clk) begin
    if (finish && !launch) begin
      occurrences <= '0;
      status      <= err2;
    end
    if (srch_res.done) begin
      occurrences <= srch_res.occ;
      status      <= ssoc_pkg::ST_OK;
    end
    if (launch) begin
      qlen <= cl1;
    end
  end

  a_slot_free_at_done: assert property (@(posedge clk) disable iff (rst)
    srch_res.done |-> !out_valid)
    else $error("search finished while the result register was occupied");

  a_done_posts_result: assert property (@(posedge clk) disable iff (rst)
    (busy && srch_res.done) |=> (out_valid && !busy))
    else $error("search completion did not post a result");

  a_table_held_in_search: assert property (@(posedge clk) disable iff (rst)
    busy |=> $stable(entry_count))
    else $error("entry count changed during a search");

endmodule

`default_nettype wire

FILE: hw/rtl/ssoc_ram.sv
// ----------------------------------------------------------------------------
// ssoc_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ssoc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ssoc_cmp.sv
// ----------------------------------------------------------------------------
// ssoc_cmp
// One step of the lexicographic comparison of a table entry against the query.
// ----------------------------------------------------------------------------
`default_nettype none

module ssoc_cmp #(
  parameter int LEN_W = 5
) (
  input  logic [LEN_W-1:0]          col,
  input  logic [LEN_W-1:0]          elen,
  input  logic [LEN_W-1:0]          qlen,
  input  logic [ssoc_pkg::ITEM_W-1:0] ent_item,
  input  logic [ssoc_pkg::ITEM_W-1:0] qry_item,
  output ssoc_pkg::cmp_res_t         res
);

  logic [LEN_W-1:0] n;

  assign n = (elen < qlen) ? elen : qlen;

  // Inside the common prefix the first differing item decides; past it the
  // shorter sequence ranks first.
  always_comb begin
    if (col < n) begin
      res.done = (ent_item != qry_item);
      res.gt   = (ent_item > qry_item);
      res.lt   = (ent_item < qry_item);
    end else begin
      res.done = 1'b1;
      res.gt   = (elen > qlen);
      res.lt   = (elen < qlen);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ssoc_search.sv
// ----------------------------------------------------------------------------
// ssoc_search
// Sequencer for the upper and lower bound binary searches of a query.
// ----------------------------------------------------------------------------
`default_nettype none

module ssoc_search #(
  parameter int TABLE_DEPTH = 1024,
  parameter int MAX_SEQ_LEN = 16,
  localparam int AW    = $clog2(TABLE_DEPTH),
  localparam int CW    = $clog2(TABLE_DEPTH + 1),
  localparam int LW    = (MAX_SEQ_LEN > 1) ? $clog2(MAX_SEQ_LEN) : 1,
  localparam int LEN_W = $clog2(MAX_SEQ_LEN + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [CW-1:0]                 count,
  input  logic [LEN_W-1:0]              qlen,
  input  logic [LEN_W-1:0]              ent_len,
  input  logic [ssoc_pkg::ITEM_W-1:0]   ent_item,
  input  logic [ssoc_pkg::ITEM_W-1:0]   qry_item,
  output logic [AW-1:0]                 rd_row,
  output logic [LW-1:0]                 rd_col,
  output ssoc_pkg::srch_res_t           res
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOOP  = 2'd1;
  localparam logic [1:0] S_PROBE = 2'd2;
  localparam logic [1:0] S_CMP   = 2'd3;

  logic [1:0]                  state;
  logic                        phase;
  logic [CW-1:0]               lo;
  logic [CW-1:0]               hi;
  logic [CW-1:0]               up;
  logic [AW-1:0]               mid;
  logic [LEN_W-1:0]            col;
  logic [LEN_W-1:0]            col_next;
  logic [CW:0]                 sum;
  logic [CW-1:0]               mid_inc;
  logic                        done;
  logic [ssoc_pkg::OCC_W-1:0]  occ;
  ssoc_pkg::cmp_res_t          cres;

  ssoc_cmp #(
    .LEN_W(LEN_W)
  ) u_cmp (
    .col     (col),
    .elen    (ent_len),
    .qlen    (qlen),
    .ent_item(ent_item),
    .qry_item(qry_item),
    .res     (cres)
  );

  assign sum      = {1'b0, lo} + {1'b0, hi};
  assign mid_inc  = CW'(mid) + CW'(1);
  assign col_next = col + LEN_W'(1);

  // The item read is issued in the cycle before its comparison.
  always_comb begin
    rd_row = mid;
    case (state)
      S_CMP:   rd_col = col_next[LW-1:0];
      default: rd_col = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      // The second search has closed its interval.
      done <= (state == S_LOOP) && !(lo < hi) && phase;
      case (state)
        S_IDLE: begin
          if (start) begin
            lo    <= '0;
            hi    <= count;
            phase <= 1'b0;
            state <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (lo < hi) begin
            mid   <= sum[AW:1];
            state <= S_PROBE;
          end else if (!phase) begin
            up    <= lo;
            lo    <= '0;
            phase <= 1'b1;
          end else begin
            occ   <= ssoc_pkg::OCC_W'(up - lo);
            state <= S_IDLE;
          end
        end
        S_PROBE: begin
          col   <= '0;
          state <= S_CMP;
        end
        S_CMP: begin
          if (cres.done) begin
            if (!phase) begin
              if (cres.gt) begin
                hi <= CW'(mid);
              end else begin
                lo <= mid_inc;
              end
            end else begin
              if (cres.lt) begin
                lo <= mid_inc;
              end else begin
                hi <= CW'(mid);
              end
            end
            state <= S_LOOP;
          end else begin
            col <= col_next;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.done = done;
  assign res.occ  = occ;

  a_bounds_ordered: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (lo <= hi))
    else $error("search bounds crossed");

  a_col_in_prefix: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (col <= ent_len && col <= qlen))
    else $error("comparison ran past the shorter sequence");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted sequence occurrence counter.
// ----------------------------------------------------------------------------
// A queue of input transfers is built at time zero. It holds a short directed
// opening and then randomized episodes. An episode clears the table, loads a
// sorted set of short sequences and queries the table with copies of stored
// entries, fresh sequences and over-long ones. Kind changes, clears and ignored
// commands are mixed in. One episode fills the table to capacity with a single
// repeated entry, so that the table-full flag and the largest count are
// reached. A shadow copy of the table predicts every result at the moment its
// last input transfer is accepted. The receiver compares each result against
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------

module testbench;

  localparam int CMD_W    = ssoc_pkg::CMD_W;
  localparam int ITEM_W   = ssoc_pkg::ITEM_W;
  localparam int OCC_W    = ssoc_pkg::OCC_W;
  localparam int STATUS_W = ssoc_pkg::STATUS_W;

  localparam int DEPTH        = 1024;
  localparam int MAX_LEN      = 16;
  localparam int SEQ_CAP      = MAX_LEN + 4;  // room for over-long sequences
  localparam int CLK_HALF     = 10;
  localparam int RST_CYCLES   = 6;
  localparam int CYCLE_LIMIT  = 4000000;
  localparam int DRAIN_CYCLES = 1000;         // above the worst search time
  localparam int HOLD_AFTER   = 150;          // accepted transfers before the hold
  localparam int HOLD_CYCLES  = 1500;
  localparam int ITEM_TARGET  = 1550;
  localparam int FILL_AFTER   = 300;
  localparam int MAX_REPORTS  = 20;

  // One input transfer, in port order.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ITEM_W-1:0] item_id;
    logic              no_item;
    logic              last;
  } xfer_t;

  // An item sequence. Only the first len items are meaningful.
  typedef struct packed {
    logic [5:0]                     len;
    logic [SEQ_CAP-1:0][ITEM_W-1:0] itm;
  } seq_t;

  // One result transfer.
  typedef struct packed {
    logic [OCC_W-1:0]    occ;
    logic [STATUS_W-1:0] st;
  } outcome_t;

  // The receiver's stall patterns. Each one is held for a random stretch.
  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_EVERY_FOURTH,
    READY_SPARSE
  } ready_mode_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    cmd = ssoc_pkg::CMD_LOAD;
  logic [ITEM_W-1:0]   item_id = '0;
  logic                no_item = 1'b0;
  logic                last = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [OCC_W-1:0]    occurrences;
  logic [STATUS_W-1:0] status;

  sorted_sequence_occurrence_counter_top #(
    .TABLE_DEPTH (DEPTH),
    .MAX_SEQ_LEN (MAX_LEN)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .item_id     (item_id),
    .no_item     (no_item),
    .last        (last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .occurrences (occurrences),
    .status      (status)
  );

  always #CLK_HALF clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow table and result prediction
  // --------------------------------------------------------------------------
  // The shadow keeps the stored entries, the sequence that is being streamed,
  // the status that sequence will report and which kind (load or query) it
  // is. The kind survives a clear, as in the block.
  seq_t                shadow_entries [DEPTH];
  int unsigned         shadow_count = 0;
  seq_t                open_seq = '0;
  logic [STATUS_W-1:0] open_status = ssoc_pkg::ST_OK;
  logic [CMD_W-1:0]    open_cmd = ssoc_pkg::CMD_LOAD;
  outcome_t            expected_results [$];

  // Lexicographic order of two sequences, where a proper prefix ranks first.
  function automatic int seq_order(seq_t a, seq_t b);
    int n;
    int i;
    n = (a.len < b.len) ? int'(a.len) : int'(b.len);
    for (i = 0; i < n; i++) begin
      if (a.itm[i] > b.itm[i]) return 1;
      if (a.itm[i] < b.itm[i]) return -1;
    end
    if (a.len > b.len) return 1;
    if (a.len < b.len) return -1;
    return 0;
  endfunction

  // Upper bound minus lower bound over the table as stored. On an unsorted
  // table this is whatever difference the two searches produce.
  function automatic int unsigned count_equal_entries(seq_t q);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned upper;
    lo = 0;
    hi = shadow_count;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (seq_order(shadow_entries[mid], q) > 0) hi = mid;
      else lo = mid + 1;
    end
    upper = lo;
    lo = 0;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (seq_order(shadow_entries[mid], q) < 0) lo = mid + 1;
      else hi = mid;
    end
    return upper - lo;
  endfunction

  // Applies one accepted input transfer to the shadow. A transfer marked last
  // queues the result that it must produce.
  function automatic void predict_transfer(xfer_t x);
    outcome_t res;
    if (x.cmd == ssoc_pkg::CMD_UNUSED) return;
    if (x.cmd == ssoc_pkg::CMD_CLEAR) begin
      shadow_count = 0;
      open_seq.len = '0;
      open_status = ssoc_pkg::ST_OK;
      return;
    end
    // Switching between loading and querying drops the partial sequence.
    if (x.cmd != open_cmd) begin
      open_cmd = x.cmd;
      open_seq.len = '0;
      open_status = ssoc_pkg::ST_OK;
    end
    if (x.cmd == ssoc_pkg::CMD_LOAD && shadow_count >= DEPTH)
      open_status = ssoc_pkg::ST_FULL;
    if (!x.no_item) begin
      if (open_seq.len >= MAX_LEN) begin
        if (open_status == ssoc_pkg::ST_OK) open_status = ssoc_pkg::ST_LONG;
      end else if (open_status == ssoc_pkg::ST_OK) begin
        open_seq.itm[open_seq.len] = x.item_id;
        open_seq.len = open_seq.len + 1'b1;
      end
    end
    if (!x.last) return;
    res.occ = '0;
    res.st = open_status;
    if (open_status == ssoc_pkg::ST_OK) begin
      if (x.cmd == ssoc_pkg::CMD_LOAD) begin
        shadow_entries[shadow_count] = open_seq;
        shadow_count++;
      end else begin
        res.occ = OCC_W'(count_equal_entries(open_seq));
      end
    end
    expected_results.push_back(res);
    open_seq.len = '0;
    open_status = ssoc_pkg::ST_OK;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------
  xfer_t pending_xfers [$];
  int    stim_items = 0;

  // Ignored commands are queued but not counted toward the item target.
  task automatic push_xfer(logic [CMD_W-1:0] c, logic [ITEM_W-1:0] id,
                           logic n, logic l);
    pending_xfers.push_back({c, id, n, l});
    if (c != ssoc_pkg::CMD_UNUSED) stim_items++;
  endtask

  // Item values favor a small alphabet so that equal entries and shared
  // prefixes are common, with the top of the range and full-width values too.
  function automatic logic [ITEM_W-1:0] rand_item();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return ITEM_W'($urandom_range(0, 3));
    if (r < 8) return 16'hFFFF - ITEM_W'($urandom_range(0, 1));
    return ITEM_W'($urandom);
  endfunction

  function automatic seq_t rand_seq(int min_len, int max_len);
    seq_t s;
    int i;
    s = '0;
    s.len = 6'($urandom_range(max_len, min_len));
    for (i = 0; i < int'(s.len); i++) s.itm[i] = rand_item();
    return s;
  endfunction

  // Mostly short sequences, now and then up to the full length.
  function automatic seq_t typical_seq();
    if ($urandom_range(0, 9) < 8) return rand_seq(0, 4);
    return rand_seq(5, MAX_LEN);
  endfunction

  // Streams one sequence. With noise on, empty steps and ignored commands are
  // slipped in, and sometimes the sequence is closed by an empty last step.
  task automatic send_seq(logic [CMD_W-1:0] c, seq_t s, bit noisy);
    bit tail;
    int i;
    if (s.len == 0) begin
      push_xfer(c, ITEM_W'($urandom), 1'b1, 1'b1);
      return;
    end
    tail = noisy && ($urandom_range(0, 7) == 0);
    for (i = 0; i < int'(s.len); i++) begin
      if (noisy && $urandom_range(0, 11) == 0)
        push_xfer(c, ITEM_W'($urandom), 1'b1, 1'b0);
      if (noisy && $urandom_range(0, 29) == 0)
        push_xfer(ssoc_pkg::CMD_UNUSED, ITEM_W'($urandom), 1'($urandom), 1'($urandom));
      push_xfer(c, s.itm[i], 1'b0, !tail && (i == int'(s.len) - 1));
    end
    if (tail) push_xfer(c, ITEM_W'($urandom), 1'b1, 1'b1);
  endtask

  // Opens a sequence of the given kind and leaves it open, so that the next
  // transfer of the other kind throws it away.
  task automatic send_partial(logic [CMD_W-1:0] c);
    seq_t s;
    int i;
    s = rand_seq(1, 3);
    for (i = 0; i < int'(s.len); i++) push_xfer(c, s.itm[i], 1'b0, 1'b0);
  endtask

  // A sorted table followed by a burst of queries against it. Skipping the
  // clear appends to the old table, which usually leaves it unsorted.
  task automatic run_episode();
    seq_t tbl [32];
    seq_t s;
    seq_t held;
    int n;
    int q;
    int i;
    int j;
    int r;
    if ($urandom_range(0, 4) != 0)
      push_xfer(ssoc_pkg::CMD_CLEAR, ITEM_W'($urandom), 1'($urandom), 1'($urandom));
    if ($urandom_range(0, 3) == 0) send_partial(ssoc_pkg::CMD_QUERY);
    n = $urandom_range(0, 31);
    for (i = 0; i < n; i++) tbl[i] = typical_seq();
    for (i = 1; i < n; i++) begin
      held = tbl[i];
      j = i;
      while (j > 0 && seq_order(tbl[j-1], held) > 0) begin
        tbl[j] = tbl[j-1];
        j--;
      end
      tbl[j] = held;
    end
    for (i = 0; i < n; i++) begin
      // An over-long entry is dropped, so the order is kept.
      if ($urandom_range(0, 15) == 0)
        send_seq(ssoc_pkg::CMD_LOAD, rand_seq(MAX_LEN + 1, SEQ_CAP), 1'b1);
      send_seq(ssoc_pkg::CMD_LOAD, tbl[i], 1'b1);
    end
    q = $urandom_range(4, 12);
    for (i = 0; i < q; i++) begin
      r = $urandom_range(0, 9);
      if (r < 6 && n > 0) s = tbl[$urandom_range(0, n - 1)];
      else if (r < 9) s = typical_seq();
      else s = rand_seq(MAX_LEN + 1, SEQ_CAP);
      if ($urandom_range(0, 9) == 0) send_partial(ssoc_pkg::CMD_LOAD);
      send_seq(ssoc_pkg::CMD_QUERY, s, 1'b1);
    end
  endtask

  // Fills the table with one repeated single-item entry. Further loads must
  // then report a full table, and the repeated entry matches every slot.
  task automatic run_fill_episode();
    seq_t s;
    seq_t t;
    int i;
    push_xfer(ssoc_pkg::CMD_CLEAR, ITEM_W'($urandom), 1'($urandom), 1'($urandom));
    s = '0;
    s.len = 6'd1;
    s.itm[0] = ITEM_W'($urandom);
    for (i = 0; i < DEPTH; i++) send_seq(ssoc_pkg::CMD_LOAD, s, 1'b0);
    send_seq(ssoc_pkg::CMD_LOAD, s, 1'b0);
    t = '0;
    send_seq(ssoc_pkg::CMD_LOAD, t, 1'b0);
    // Table full takes precedence over a sequence that is too long.
    send_seq(ssoc_pkg::CMD_LOAD, rand_seq(MAX_LEN + 1, SEQ_CAP), 1'b0);
    send_seq(ssoc_pkg::CMD_QUERY, s, 1'b1);
    send_seq(ssoc_pkg::CMD_QUERY, t, 1'b1);
    t = s;
    t.itm[0] = s.itm[0] ^ 16'h0001;
    send_seq(ssoc_pkg::CMD_QUERY, t, 1'b1);
    t = s;
    t.len = 6'd2;
    t.itm[1] = rand_item();
    send_seq(ssoc_pkg::CMD_QUERY, t, 1'b1);
    send_seq(ssoc_pkg::CMD_QUERY, rand_seq(MAX_LEN + 1, SEQ_CAP), 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps. A new transfer
  // is presented only when the slot is free, so valid and the payload hold
  // steady until the block accepts them.
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    xfer_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_xfers.size() > 0) begin
        nxt = pending_xfers.pop_front();
        cmd <= nxt.cmd;
        item_id <= nxt.item_id;
        no_item <= nxt.no_item;
        last <= nxt.last;
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          // A gap of zero merges two bursts into one longer stretch.
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: a stall pattern that is redrawn when its random stretch runs out, plus one
  // long hold while the sender keeps offering transfers. The hold lets the
  // block back up until it stops accepting input.
  // --------------------------------------------------------------------------
  ready_mode_t ready_mode = READY_ALWAYS;
  int          mode_left = 0;
  logic        stall_hold = 1'b0;
  int          cycle_count = 0;
  int          accepted_xfers = 0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      mode_left <= $urandom_range(32, 256);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (rst || stall_hold) begin
      out_ready <= 1'b0;
    end else begin
      case (ready_mode)
        READY_ALWAYS:       out_ready <= 1'b1;
        READY_COIN:         out_ready <= 1'($urandom);
        READY_EVERY_FOURTH: out_ready <= (cycle_count % 4 == 0);
        default:            out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  initial begin
    while (accepted_xfers < HOLD_AFTER) @(posedge clk);
    stall_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    stall_hold <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction and checking. Each accepted input transfer updates the shadow
  // first. Each accepted result is then compared with the oldest prediction.
  // --------------------------------------------------------------------------
  int mismatches = 0;
  int results_seen = 0;
  int query_hits = 0;
  int full_flags = 0;
  int long_flags = 0;
  int max_count = 0;

  task automatic report_mismatch(string field_name, int unsigned got_v,
                                 int unsigned want_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("MISMATCH at result %0d (cycle %0d): %s: got %0d, expected %0d",
               results_seen, cycle_count, field_name, got_v, want_v);
  endtask

  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_transfer({cmd, item_id, no_item, last});
        accepted_xfers <= accepted_xfers + 1;
      end
      if (out_valid && out_ready) begin
        got.occ = occurrences;
        got.st = status;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected, occurrences",
                          got.occ, 0);
        end else begin
          want = expected_results.pop_front();
          if (got.occ != want.occ) report_mismatch("occurrences", got.occ, want.occ);
          if (got.st != want.st) report_mismatch("status", got.st, want.st);
          if (want.occ != 0) query_hits++;
          if (want.st == ssoc_pkg::ST_FULL) full_flags++;
          if (want.st == ssoc_pkg::ST_LONG) long_flags++;
          if (int'(want.occ) > max_count) max_count = want.occ;
        end
        results_seen++;
      end
    end
  end

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d transfers queued and %0d results due",
               cycle_count, pending_xfers.size(), expected_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    bit fill_done;
    fill_done = 1'b0;

    // An empty query on an empty table.
    push_xfer(ssoc_pkg::CMD_QUERY, ITEM_W'($urandom), 1'b1, 1'b1);
    // Sorted table: empty, [0], [0 FFFF], [FFFF], [FFFF].
    push_xfer(ssoc_pkg::CMD_LOAD, ITEM_W'($urandom), 1'b1, 1'b1);
    push_xfer(ssoc_pkg::CMD_LOAD, 16'h0000, 1'b0, 1'b1);
    push_xfer(ssoc_pkg::CMD_LOAD, 16'h0000, 1'b0, 1'b0);
    push_xfer(ssoc_pkg::CMD_LOAD, 16'hFFFF, 1'b0, 1'b1);
    push_xfer(ssoc_pkg::CMD_LOAD, 16'hFFFF, 1'b0, 1'b1);
    push_xfer(ssoc_pkg::CMD_LOAD, 16'hFFFF, 1'b0, 1'b1);
    // A duplicated entry at the top of the table.
    push_xfer(ssoc_pkg::CMD_QUERY, 16'hFFFF, 1'b0, 1'b1);
    // An empty step and an ignored command inside an open query.
    push_xfer(ssoc_pkg::CMD_QUERY, 16'h0000, 1'b0, 1'b0);
    push_xfer(ssoc_pkg::CMD_QUERY, ITEM_W'($urandom), 1'b1, 1'b0);
    push_xfer(ssoc_pkg::CMD_UNUSED, ITEM_W'($urandom), 1'b0, 1'b1);
    push_xfer(ssoc_pkg::CMD_QUERY, 16'hFFFF, 1'b0, 1'b1);
    // A query closed by an empty last step, then the empty query itself.
    push_xfer(ssoc_pkg::CMD_QUERY, 16'h0000, 1'b0, 1'b0);
    push_xfer(ssoc_pkg::CMD_QUERY, ITEM_W'($urandom), 1'b1, 1'b1);
    push_xfer(ssoc_pkg::CMD_QUERY, ITEM_W'($urandom), 1'b1, 1'b1);
    // A sequence that falls between stored entries.
    push_xfer(ssoc_pkg::CMD_QUERY, 16'h8000, 1'b0, 1'b1);
    // A partial load dropped by a query.
    push_xfer(ssoc_pkg::CMD_LOAD, 16'h1234, 1'b0, 1'b0);
    push_xfer(ssoc_pkg::CMD_QUERY, 16'h0000, 1'b0, 1'b1);
    // A partial query dropped by a load that extends the sorted table.
    push_xfer(ssoc_pkg::CMD_QUERY, 16'h0000, 1'b0, 1'b0);
    push_xfer(ssoc_pkg::CMD_LOAD, 16'hFFFF, 1'b0, 1'b0);
    push_xfer(ssoc_pkg::CMD_LOAD, 16'h0001, 1'b0, 1'b1);
    // A clear in the middle of an open load empties the table.
    push_xfer(ssoc_pkg::CMD_LOAD, 16'h0005, 1'b0, 1'b0);
    push_xfer(ssoc_pkg::CMD_CLEAR, ITEM_W'($urandom), 1'b1, 1'b1);
    push_xfer(ssoc_pkg::CMD_QUERY, 16'hFFFF, 1'b0, 1'b1);

    while (stim_items < ITEM_TARGET) begin
      if (!fill_done && stim_items >= FILL_AFTER) begin
        run_fill_episode();
        fill_done = 1'b1;
      end else begin
        run_episode();
      end
    end

    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Wait until every transfer has gone in and every result has come out,
    // then give a stray result time to show up.
    while (pending_xfers.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d input transfers and %0d results in %0d cycles.",
             accepted_xfers, results_seen, cycle_count);
    $display("Matching queries: %0d, largest count %0d, full flags %0d, long flags %0d.",
             query_hits, max_count, full_flags, long_flags);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
